### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset
`define ALC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// condition that must never hold
`define ALC_NEVER(lbl, clk, rstn, cond) \
  `ALC_ASSERT(lbl, clk, rstn, !(cond))

`endif

### rtl/alc_pkg.sv
// types, codes and constants of the address lease client engine
package alc_pkg;

  localparam int ALC_PORTS   = 8;
  localparam int ALC_MAX_RES = 16;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_OFFER  = 3'd1;
  localparam logic [2:0] CMD_ACK    = 3'd2;
  localparam logic [2:0] CMD_WATCH  = 3'd3;
  localparam logic [2:0] CMD_UNWTCH = 3'd4;
  localparam logic [2:0] CMD_REMOVE = 3'd5;
  localparam logic [2:0] CMD_DUP    = 3'd6;

  localparam logic [2:0] ACT_DISCOVER = 3'd0;
  localparam logic [2:0] ACT_REQUEST  = 3'd1;
  localparam logic [2:0] ACT_DECLINE  = 3'd2;
  localparam logic [2:0] ACT_CLEAR    = 3'd3;
  localparam logic [2:0] ACT_APPLY    = 3'd4;
  localparam logic [2:0] ACT_PROBE    = 3'd5;

  localparam logic [1:0] PH_BOUND      = 2'd0;
  localparam logic [1:0] PH_WAIT_OFFER = 2'd1;
  localparam logic [1:0] PH_WAIT_ACK   = 2'd2;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RETRY   = 2'd1;
  localparam logic [1:0] CFG_ENABLE  = 2'd2;

  typedef enum logic [1:0] {
    OP_DEC,
    OP_INC,
    OP_EQ
  } alc_op_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  port;
    logic [12:0] new_xid;
    logic [31:0] packet_xid;
    logic [31:0] server_addr;
    logic [31:0] offered_ip;
    logic [31:0] offered_mask;
    logic [31:0] offered_gateway;
    logic [30:0] lease_time;
    logic [7:0]  link_mask;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  out_port;
    logic [12:0] out_xid;
    logic [31:0] out_server;
    logic [31:0] out_ip;
    logic [31:0] out_mask;
    logic [31:0] out_gateway;
    logic        last;
  } out_t;

endpackage

### rtl/alc_alu.sv
// shared decrement, increment-compare and equality unit
module alc_alu
  import alc_pkg::*;
(
  input  alc_op_e     op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o,
  output logic        flag_o
);

  always_comb begin
    res_o  = a_i;
    flag_o = 1'b0;
    case (op_i)
      OP_DEC: begin
        res_o  = (a_i == 32'd0) ? 32'd0 : a_i - 32'd1;
        flag_o = (res_o == 32'd0);
      end
      OP_INC: begin
        res_o  = a_i + 32'd1;
        flag_o = (res_o > b_i);
      end
      OP_EQ: begin
        flag_o = (a_i == b_i);
      end
      default: begin
        res_o  = a_i;
        flag_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/address_lease_client_engine.sv
// address lease client engine: per-port lease table with a slot sequencer
//
// Input beats (in_valid_i / in_stall_o) carry one event: a tick, a received
// offer or ack, or a watch, unwatch, remove or duplicate-address event.
// in_stall_o is high from the accepting edge until every result of that beat
// has been loaded into the output register. Output beats (out_valid_o /
// out_stall_i) carry one action each; last marks the final action of an event.
// A tick or packet walks the slots one by one through the shared unit, with
// micro-steps (clear, discover, request, apply, probe) in each slot that
// needs them; a port event works on its own port only. Each action waits one
// stage in a pending register so the last flag can be set, then moves to the
// output register. When the receiver stalls, the sequencer holds at the step
// that wants to emit. Reset empties the table, loads timeout 60, retry limit 3
// and enable 1, and the block can take a beat directly after reset.
`include "assert_macros.svh"

module address_lease_client_engine
  import alc_pkg::*;
#(
  parameter int PORTS = ALC_PORTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int CW = $clog2(ALC_MAX_RES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_CLR, ST_DISC, ST_REQ, ST_APPLY, ST_PROBE,
    ST_DECL, ST_UNW, ST_FLUSH
  } state_e;

  state_e state_q;
  logic [PW-1:0] ptr_q;
  in_t in_q;
  logic [CW-1:0] cnt_q;

  logic [15:0] timeout_q;
  logic [7:0]  limit_q;
  logic        enable_q;

  logic        valid_q  [PORTS];
  logic [1:0]  phase_q  [PORTS];
  logic [31:0] timer_q  [PORTS];
  logic [7:0]  retry_q  [PORTS];
  logic [12:0] xid_q    [PORTS];
  logic [31:0] server_q [PORTS];
  logic [31:0] lastip_q [PORTS];

  out_t pend_q;
  logic pend_valid_q;
  out_t out_q;
  logic out_valid_q;

  alc_op_e     alu_op;
  logic [31:0] alu_a, alu_b, alu_res;
  logic        alu_flag;
  logic        e_want, emit_ok, last_slot, link, is_tick;
  out_t        e_res;
  logic [3:0]  ptr4;

  alc_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .flag_o(alu_flag)
  );

  assign ptr4      = 4'(ptr_q);
  assign link      = !ptr4[3] && in_q.link_mask[ptr4[2:0]];
  assign last_slot = (ptr_q == PW'(PORTS - 1));
  assign is_tick   = (in_q.command == CMD_TICK);
  assign emit_ok   = !pend_valid_q || !out_valid_q || !out_stall_i;

  always_comb begin
    alu_op = OP_EQ;
    alu_a  = {19'd0, xid_q[ptr_q]};
    alu_b  = in_q.packet_xid;
    e_want = 1'b0;
    e_res  = '0;
    e_res.out_port = 3'(ptr_q);
    case (state_q)
      ST_EVAL: begin
        if (is_tick) begin
          alu_op = OP_DEC;
          alu_a  = timer_q[ptr_q];
        end
      end
      ST_CLR, ST_UNW: begin
        e_want       = 1'b1;
        e_res.action = ACT_CLEAR;
      end
      ST_DISC: begin
        e_want        = link;
        e_res.action  = ACT_DISCOVER;
        e_res.out_xid = xid_q[ptr_q];
        e_res.out_ip  = lastip_q[ptr_q];
      end
      ST_REQ: begin
        alu_op           = OP_INC;
        alu_a            = {24'd0, retry_q[ptr_q]};
        alu_b            = {24'd0, limit_q};
        e_want           = link && !alu_flag;
        e_res.action     = ACT_REQUEST;
        e_res.out_xid    = xid_q[ptr_q];
        e_res.out_server = server_q[ptr_q];
      end
      ST_APPLY: begin
        e_want            = 1'b1;
        e_res.action      = ACT_APPLY;
        e_res.out_ip      = in_q.offered_ip;
        e_res.out_mask    = in_q.offered_mask;
        e_res.out_gateway = in_q.offered_gateway;
      end
      ST_PROBE: begin
        e_want       = 1'b1;
        e_res.action = ACT_PROBE;
        e_res.out_ip = in_q.offered_ip;
      end
      ST_DECL: begin
        e_want        = link;
        e_res.action  = ACT_DECLINE;
        e_res.out_xid = xid_q[ptr_q];
        e_res.out_ip  = lastip_q[ptr_q];
      end
      default: begin
        e_want = 1'b0;
      end
    endcase
    // results past the limit are dropped
    if (cnt_q >= CW'(ALC_MAX_RES)) e_want = 1'b0;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ptr_q        <= '0;
      cnt_q        <= '0;
      in_q         <= '0;
      timeout_q    <= 16'd60;
      limit_q      <= 8'd3;
      enable_q     <= 1'b1;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < PORTS; i++) begin
        valid_q[i]  <= 1'b0;
        phase_q[i]  <= PH_BOUND;
        timer_q[i]  <= '0;
        retry_q[i]  <= '0;
        xid_q[i]    <= '0;
        server_q[i] <= '0;
        lastip_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
          CFG_RETRY:   limit_q   <= cfg_wdata_i[7:0];
          CFG_ENABLE:  enable_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      // push one action through pending into the output register
      if (e_want && emit_ok) begin
        if (pend_valid_q) begin
          out_q       <= pend_q;
          out_valid_q <= 1'b1;
        end
        pend_q       <= e_res;
        pend_valid_q <= 1'b1;
        cnt_q        <= cnt_q + CW'(1);
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q  <= in_data_i;
            cnt_q <= '0;
            ptr_q <= '0;
            state_q <= ST_FLUSH;
            if (in_data_i.command == CMD_TICK || in_data_i.command == CMD_OFFER ||
                in_data_i.command == CMD_ACK) begin
              state_q <= ST_EVAL;
            end else if (int'(in_data_i.port) < PORTS) begin
              ptr_q <= PW'(in_data_i.port);
              case (in_data_i.command)
                CMD_WATCH: begin
                  if (enable_q && !valid_q[PW'(in_data_i.port)]) begin
                    valid_q[PW'(in_data_i.port)]  <= 1'b1;
                    xid_q[PW'(in_data_i.port)]    <= in_data_i.new_xid;
                    server_q[PW'(in_data_i.port)] <= '0;
                    lastip_q[PW'(in_data_i.port)] <= '0;
                    state_q <= ST_DISC;
                  end
                end
                CMD_UNWTCH: begin
                  if (enable_q && valid_q[PW'(in_data_i.port)]) state_q <= ST_UNW;
                end
                CMD_REMOVE: valid_q[PW'(in_data_i.port)] <= 1'b0;
                CMD_DUP: begin
                  if (valid_q[PW'(in_data_i.port)]) state_q <= ST_DECL;
                end
                default: ;
              endcase
            end
          end
        end
        ST_EVAL: begin
          if (is_tick) begin
            if (valid_q[ptr_q]) timer_q[ptr_q] <= alu_res;
            if (valid_q[ptr_q] && alu_flag && phase_q[ptr_q] == PH_BOUND) begin
              state_q <= ST_CLR;
            end else if (valid_q[ptr_q] && alu_flag &&
                         phase_q[ptr_q] == PH_WAIT_OFFER) begin
              state_q <= ST_DISC;
            end else if (valid_q[ptr_q] && alu_flag &&
                         phase_q[ptr_q] == PH_WAIT_ACK) begin
              state_q <= ST_REQ;
            end else if (last_slot) begin
              state_q <= ST_FLUSH;
            end else begin
              ptr_q <= ptr_q + PW'(1);
            end
          end else begin
            if (valid_q[ptr_q] && alu_flag && in_q.command == CMD_OFFER &&
                phase_q[ptr_q] == PH_WAIT_OFFER) begin
              phase_q[ptr_q]  <= PH_WAIT_ACK;
              server_q[ptr_q] <= in_q.server_addr;
              state_q <= ST_REQ;
            end else if (valid_q[ptr_q] && alu_flag && in_q.command == CMD_ACK &&
                         phase_q[ptr_q] == PH_WAIT_ACK) begin
              phase_q[ptr_q]  <= PH_BOUND;
              timer_q[ptr_q]  <= 32'(in_q.lease_time);
              lastip_q[ptr_q] <= in_q.offered_ip;
              state_q <= ST_APPLY;
            end else if (last_slot) begin
              state_q <= ST_FLUSH;
            end else begin
              ptr_q <= ptr_q + PW'(1);
            end
          end
        end
        ST_CLR: begin
          if (!(e_want && !emit_ok)) state_q <= ST_DISC;
        end
        ST_UNW: begin
          if (!(e_want && !emit_ok)) begin
            valid_q[ptr_q] <= 1'b0;
            state_q <= ST_FLUSH;
          end
        end
        ST_DISC: begin
          if (!(e_want && !emit_ok)) begin
            phase_q[ptr_q] <= PH_WAIT_OFFER;
            timer_q[ptr_q] <= 32'(timeout_q);
            retry_q[ptr_q] <= '0;
            if (is_tick && !last_slot) begin
              ptr_q   <= ptr_q + PW'(1);
              state_q <= ST_EVAL;
            end else begin
              state_q <= ST_FLUSH;
            end
          end
        end
        ST_REQ: begin
          if (alu_flag) begin
            // too many requests: restart the session
            state_q <= ST_CLR;
          end else if (!(e_want && !emit_ok)) begin
            retry_q[ptr_q] <= alu_res[7:0];
            timer_q[ptr_q] <= 32'(timeout_q);
            if (is_tick && !last_slot) begin
              ptr_q   <= ptr_q + PW'(1);
              state_q <= ST_EVAL;
            end else begin
              state_q <= ST_FLUSH;
            end
          end
        end
        ST_APPLY: begin
          if (!(e_want && !emit_ok)) state_q <= ST_PROBE;
        end
        ST_PROBE: begin
          if (!(e_want && !emit_ok)) state_q <= ST_FLUSH;
        end
        ST_DECL: begin
          if (!(e_want && !emit_ok)) begin
            xid_q[ptr_q]    <= in_q.new_xid;
            lastip_q[ptr_q] <= '0;
            state_q <= ST_CLR;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (!out_valid_q || !out_stall_i) begin
            out_q       <= pend_q;
            out_q.last  <= 1'b1;
            out_valid_q <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ALC_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(ALC_MAX_RES))
  `ALC_NEVER(a_idle_pend, clk_i, rst_ni, state_q == ST_IDLE && pend_valid_q)
  `ALC_ASSERT(a_last_alone, clk_i, rst_ni,
              (out_valid_o && out_data_o.last && state_q == ST_IDLE) |-> !pend_valid_q)

endmodule
